>>> hdl/pidc_pkg.sv
// Shared types and constants of the single-axis PID controller.
package pidc_pkg;

   // Request command codes
   localparam logic [1:0] CMD_UPDATE        = 2'd0;
   localparam logic [1:0] CMD_FULL_RESET    = 2'd1;
   localparam logic [1:0] CMD_PARTIAL_RESET = 2'd2;

   // Configuration register indexes
   localparam int         CSR_INDEX_W        = 3;
   localparam logic [2:0] CSR_GAIN_P         = 3'd0;
   localparam logic [2:0] CSR_GAIN_I         = 3'd1;
   localparam logic [2:0] CSR_GAIN_D         = 3'd2;
   localparam logic [2:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [2:0] CSR_OUTPUT_LIMIT   = 3'd4;

   // Configuration reset values
   localparam logic [15:0] GAIN_P_RESET         = 16'd6144;
   localparam logic [15:0] GAIN_I_RESET         = 16'd205;
   localparam logic [15:0] GAIN_D_RESET         = 16'd0;
   localparam logic [14:0] INTEGRAL_LIMIT_RESET = 15'd128;
   localparam logic [14:0] OUTPUT_LIMIT_RESET   = 15'd384;

   // Divider: two quotient bits per cycle over a 50-bit dividend
   localparam int DIV_WIDTH = 50;
   localparam int DIV_STEPS = DIV_WIDTH / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Datapath operation selected by the controller in each cycle
   typedef enum logic [2:0] {
      OP_NONE,
      OP_MUL_E,
      OP_ACC,
      OP_MUL_I,
      OP_IDIV,
      OP_IADD,
      OP_DIV_STEP,
      OP_DADD
   } dp_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic      capture;
      logic      clr_state;
      logic      clr_flag;
      logic      load_out;
      dp_op_type op;
   } ctrl_cmd_type;

endpackage

>>> hdl/pid_axis_controller_unit.sv
// Top level of the single-axis PID controller with anti-windup clamp.
//
// Usage:
//   Requests arrive on req_* (valid/ready): command, setpoint, measured and
//   step_time. An update request yields one response on rsp_* (drive,
//   skipped); full and partial reset requests and the unused command code
//   yield none. csr_* writes the gains and limits by register index; it is
//   always ready, but the user must write it only while no request is in
//   flight; the block itself does not enforce this.
//   Sequence: an update with nonzero step_time runs seven sequencer steps
//   around one shared 33x17 multiplier plus the two-bit-per-cycle
//   derivative divider; one with zero step_time goes straight to output.
//   Reset commands finish in the idle state. One request at a time: a new
//   request is accepted only once the controller is back in idle.
//   Reset: clears the integral, the stored error and the first-update flag,
//   and restores default gains and limits.
//   Stall: a finished response waits in the output register; the next
//   request is still accepted and runs until its own response is due.
module pid_axis_controller_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic signed [15:0]     req_setpoint,
   input  logic signed [15:0]     req_measured,
   input  logic [15:0]            req_step_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_drive,
   output logic                   rsp_skipped,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);
   import pidc_pkg::*;

   ctrl_cmd_type ctl;
   logic         dt_zero;
   logic         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   pidc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .dt_zero     (dt_zero),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctl         (ctl)
   );

   pidc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_setpoint  (req_setpoint),
      .req_measured  (req_measured),
      .req_step_time (req_step_time),
      .dt_zero       (dt_zero),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_drive     (rsp_drive),
      .rsp_skipped   (rsp_skipped)
   );

endmodule

>>> hdl/pidc_ctrl.sv
// Controller state machine that sequences one PID request through the datapath.
module pidc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic                  dt_zero,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pidc_pkg::ctrl_cmd_type ctl
);
   import pidc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_E,
      ST_ACC,
      ST_MUL_I,
      ST_IDIV,
      ST_IADD,
      ST_DIV,
      ST_DADD,
      ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Sequence the steps of one request
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctl          = '0;
      ctl.op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_UPDATE) begin
                  ctl.capture = 1'b1;
                  state_in    = dt_zero ? ST_OUT : ST_MUL_E;
               end else if (req_command == CMD_FULL_RESET) begin
                  ctl.clr_state = 1'b1;
                  ctl.clr_flag  = 1'b1;
               end else if (req_command == CMD_PARTIAL_RESET) begin
                  ctl.clr_state = 1'b1;
               end
            end
         end
         ST_MUL_E: begin
            ctl.op   = OP_MUL_E;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctl.op   = OP_ACC;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            ctl.op   = OP_MUL_I;
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            ctl.op   = OP_IDIV;
            state_in = ST_IADD;
         end
         ST_IADD: begin
            ctl.op   = OP_IADD;
            cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctl.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_DADD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DADD: begin
            ctl.op   = OP_DADD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/pidc_dp.sv
// Datapath of the PID controller: registers, shared multiplier, divider and saturation.
module pidc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pidc_pkg::ctrl_cmd_type ctl,
   input  logic signed [15:0]     req_setpoint,
   input  logic signed [15:0]     req_measured,
   input  logic [15:0]            req_step_time,
   output logic                   dt_zero,
   input  logic                   csr_write,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data,
   output logic signed [15:0]     rsp_drive,
   output logic                   rsp_skipped
);
   import pidc_pkg::*;

   // Configuration
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [14:0] int_limit_ff, out_limit_ff;

   // Controller state
   logic signed [31:0] integ_ff, integ_in;
   logic signed [16:0] last_err_ff;
   logic               have_last_ff;

   // Per-request working registers
   logic signed [16:0]          err_ff;
   logic signed [17:0]          diff_ff;
   logic [15:0]                 dt_ff;
   logic                        hl_ff;
   logic                        skip_ff;
   logic signed [49:0]          prod_ff;
   logic signed [33:0]          iterm_ff;
   logic signed [51:0]          total_ff, total_in;
   logic [DIV_WIDTH-1:0]        quo_ff, quo_in;
   logic [15:0]                 rem_ff, rem_in;
   logic                        dsign_ff;
   logic signed [15:0]          drive_ff;
   logic                        skipped_ff;

   // Error and derivative difference of the incoming request
   logic signed [16:0] err_new;
   logic signed [17:0] diff_new;

   assign dt_zero  = (req_step_time == '0);
   assign err_new  = 17'(req_setpoint) - 17'(req_measured);
   assign diff_new = 18'(err_new) - 18'(last_err_ff);

   // Shared multiplier, operands selected by the current step
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] mul_p;

   always_comb begin
      unique case (ctl.op)
         OP_MUL_E: begin
            mul_a = 33'(err_ff);
            mul_b = $signed({1'b0, dt_ff});
         end
         OP_ACC: begin
            mul_a = 33'(err_ff);
            mul_b = $signed({1'b0, gain_p_ff});
         end
         OP_MUL_I: begin
            mul_a = 33'(integ_ff);
            mul_b = $signed({1'b0, gain_i_ff});
         end
         OP_IDIV: begin
            mul_a = 33'(diff_ff);
            mul_b = $signed({1'b0, gain_d_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Integral accumulate with anti-windup clamp
   logic signed [33:0] acc_sum, ilim;

   always_comb begin
      ilim    = $signed({3'b000, int_limit_ff, 16'h0000});
      acc_sum = 34'(integ_ff) + $signed(prod_ff[33:0]);
      if (acc_sum > ilim) begin
         integ_in = ilim[31:0];
      end else if (acc_sum < -ilim) begin
         integ_in = 32'(-ilim);
      end else begin
         integ_in = acc_sum[31:0];
      end
   end

   // Integral term: divide by 2^16 truncating toward zero
   logic signed [49:0] ibias_sum;
   assign ibias_sum = prod_ff + (prod_ff[49] ? 50'sd65535 : 50'sd0);

   // Derivative magnitude for the divider
   logic signed [49:0] prod_abs;
   assign prod_abs = prod_ff[49] ? -prod_ff : prod_ff;

   // Divider: two restoring steps per cycle
   logic [16:0] r1, r1s, r2, r2s;
   logic        ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[DIV_WIDTH-1]};
      ge1 = (r1 >= {1'b0, dt_ff});
      r1s = ge1 ? (r1 - {1'b0, dt_ff}) : r1;
      r2  = {r1s[15:0], quo_ff[DIV_WIDTH-2]};
      ge2 = (r2 >= {1'b0, dt_ff});
      r2s = ge2 ? (r2 - {1'b0, dt_ff}) : r2;
   end

   logic signed [51:0] dquo;
   assign dquo = $signed({2'b00, quo_ff});

   // Next value of the working registers per step
   always_comb begin
      total_in = total_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      unique case (ctl.op)
         OP_MUL_I: total_in = 52'(prod_ff);
         OP_IADD: begin
            total_in = total_ff + 52'(iterm_ff);
            quo_in   = hl_ff ? {prod_abs[33:0], 16'h0000} : '0;
            rem_in   = '0;
         end
         OP_DIV_STEP: begin
            quo_in = {quo_ff[DIV_WIDTH-3:0], ge1, ge2};
            rem_in = r2s[15:0];
         end
         OP_DADD: total_in = dsign_ff ? (total_ff - dquo) : (total_ff + dquo);
         default: begin
         end
      endcase
   end

   // Final divide by 2^12 toward zero and output saturation
   logic signed [51:0] tbias;
   logic signed [39:0] tshift, olim;
   logic signed [15:0] drive_sat;

   always_comb begin
      tbias  = total_ff + (total_ff[51] ? 52'sd4095 : 52'sd0);
      tshift = tbias[51:12];
      olim   = $signed({25'd0, out_limit_ff});
      if (tshift > olim) begin
         drive_sat = olim[15:0];
      end else if (tshift < -olim) begin
         drive_sat = 16'(-olim);
      end else begin
         drive_sat = tshift[15:0];
      end
   end

   // Configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         int_limit_ff <= INTEGRAL_LIMIT_RESET;
         out_limit_ff <= OUTPUT_LIMIT_RESET;
         integ_ff     <= '0;
         last_err_ff  <= '0;
         have_last_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GAIN_P:         gain_p_ff    <= csr_data;
               CSR_GAIN_I:         gain_i_ff    <= csr_data;
               CSR_GAIN_D:         gain_d_ff    <= csr_data;
               CSR_INTEGRAL_LIMIT: int_limit_ff <= csr_data[14:0];
               CSR_OUTPUT_LIMIT:   out_limit_ff <= csr_data[14:0];
               default: begin
               end
            endcase
         end
         if (ctl.clr_state) begin
            integ_ff    <= '0;
            last_err_ff <= '0;
         end
         if (ctl.clr_flag) begin
            have_last_ff <= 1'b0;
         end
         if (ctl.capture && !dt_zero) begin
            last_err_ff  <= err_new;
            have_last_ff <= 1'b1;
         end
         if (ctl.op == OP_ACC) begin
            integ_ff <= integ_in;
         end
      end
   end

   // Working registers (payload, no reset)
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         skip_ff <= dt_zero;
         err_ff  <= err_new;
         diff_ff <= diff_new;
         dt_ff   <= req_step_time;
         hl_ff   <= have_last_ff;
      end
      if (ctl.op == OP_MUL_E || ctl.op == OP_ACC || ctl.op == OP_MUL_I ||
          ctl.op == OP_IDIV) begin
         prod_ff <= mul_p;
      end
      if (ctl.op == OP_IDIV) begin
         iterm_ff <= ibias_sum[49:16];
      end
      if (ctl.op == OP_IADD) begin
         dsign_ff <= prod_ff[49];
      end
      total_ff <= total_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      if (ctl.load_out) begin
         drive_ff   <= skip_ff ? 16'sd0 : drive_sat;
         skipped_ff <= skip_ff;
      end
   end

   assign rsp_drive   = drive_ff;
   assign rsp_skipped = skipped_ff;

endmodule
